// ----- design/lrpe_pkg.sv -----
package lrpe_pkg;

   // ring geometry
   localparam int LED_COUNT = 12;
   localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int FILL_W = $clog2(LED_COUNT + 1);

   // item field widths
   localparam int ACTION_W = 2;
   localparam int MASK_W = 12;
   localparam int POS_W = 4;
   localparam int COLOR_W = 8;
   localparam int IDX_OUT_W = 4;

   // configuration and timing widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 10;
   localparam int MODE_W = 3;
   localparam int PERIOD_W = 10;
   localparam int ELAPSED_W = 11;
   localparam int HUE_W = 9;
   localparam int PARAM_W = 8;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
   localparam logic [COLOR_W-1:0] COLOR_MAX = '1;

   // reset values of configuration
   localparam logic [PERIOD_W-1:0] SLOW_RESET = 10'd100;
   localparam logic [PERIOD_W-1:0] BLINK_RESET = 10'd500;
   localparam logic [PERIOD_W-1:0] FAST_RESET = 10'd5;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE  = 2'd0,
      CSR_SLOW  = 2'd1,
      CSR_BLINK = 2'd2,
      CSR_FAST  = 2'd3
   } csr_index_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK      = 2'd0,
      ACT_PRIMARY   = 2'd1,
      ACT_ALTERNATE = 2'd2
   } action_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF       = 3'd0,
      MODE_SOLID     = 3'd1,
      MODE_FOLLOWING = 3'd2,
      MODE_BLINK     = 3'd3,
      MODE_BREATHE   = 3'd4,
      MODE_RAINBOW   = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      CMD_WR_PRIMARY    = 3'd0,
      CMD_WR_ALTERNATE  = 3'd1,
      CMD_FRM_OFF       = 3'd2,
      CMD_FRM_PRIMARY   = 3'd3,
      CMD_FRM_ALTERNATE = 3'd4,
      CMD_FRM_FILL      = 3'd5,
      CMD_FRM_BREATHE   = 3'd6,
      CMD_FRM_RAINBOW   = 3'd7
   } cmd_kind_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   localparam rgb_type PRIMARY_RESET = '{red: 8'd0, green: 8'd0, blue: 8'd100};

   typedef struct packed {
      cmd_kind_type       kind;
      logic [MASK_W-1:0]  mask;
      logic [POS_W-1:0]   pos;
      rgb_type            color;
      logic [PARAM_W-1:0] param;
   } cmd_type;

   // hue start of each ring position, settled at elaboration
   typedef logic [COLOR_W-1:0] hue_base_type [LED_COUNT];

   function automatic hue_base_type build_hue_base();
      hue_base_type res;
      for (int k = 0; k < LED_COUNT; k++) begin
         res[k] = 8'((k * 256) / LED_COUNT);
      end
      return res;
   endfunction

   localparam hue_base_type HUE_BASE = build_hue_base();

   // three-segment color wheel
   function automatic rgb_type wheel(input logic [COLOR_W-1:0] p);
      rgb_type res;
      logic [COLOR_W-1:0] q;
      logic [COLOR_W-1:0] r;
      logic [COLOR_W+1:0] r3;
      q = COLOR_MAX - p;
      if (q < 8'd85) begin
         r = q;
      end else if (q < 8'd170) begin
         r = q - 8'd85;
      end else begin
         r = q - 8'd170;
      end
      r3 = 10'(r) * 10'd3;
      if (q < 8'd85) begin
         res.red = COLOR_MAX - r3[COLOR_W-1:0];
         res.green = '0;
         res.blue = r3[COLOR_W-1:0];
      end else if (q < 8'd170) begin
         res.red = '0;
         res.green = r3[COLOR_W-1:0];
         res.blue = COLOR_MAX - r3[COLOR_W-1:0];
      end else begin
         res.red = r3[COLOR_W-1:0];
         res.green = COLOR_MAX - r3[COLOR_W-1:0];
         res.blue = '0;
      end
      return res;
   endfunction

endpackage

// ----- design/lrpe_queue.sv -----
module lrpe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lrpe_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output lrpe_pkg::cmd_type head
);

   lrpe_pkg::cmd_type entry_ff [lrpe_pkg::QUEUE_DEPTH];
   logic [lrpe_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lrpe_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lrpe_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == lrpe_pkg::QCNT_W'(lrpe_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/lrpe_front.sv -----
module lrpe_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lrpe_pkg::ACTION_W-1:0]       req_action,
   input  logic [lrpe_pkg::MASK_W-1:0]         req_led_mask,
   input  logic [lrpe_pkg::POS_W-1:0]          req_led_position,
   input  logic [lrpe_pkg::COLOR_W-1:0]        req_red_in,
   input  logic [lrpe_pkg::COLOR_W-1:0]        req_green_in,
   input  logic [lrpe_pkg::COLOR_W-1:0]        req_blue_in,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lrpe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lrpe_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                push,
   output lrpe_pkg::cmd_type                   push_cmd,
   input  logic                                queue_full
);

   lrpe_pkg::mode_type mode_ff, mode_in;
   logic [lrpe_pkg::PERIOD_W-1:0] slow_ff, slow_in;
   logic [lrpe_pkg::PERIOD_W-1:0] blink_per_ff, blink_per_in;
   logic [lrpe_pkg::PERIOD_W-1:0] fast_ff, fast_in;

   logic [lrpe_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [lrpe_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic phase_ff, phase_in;
   logic falling_ff, falling_in;
   logic [lrpe_pkg::COLOR_W-1:0] level_ff, level_in;
   logic [lrpe_pkg::HUE_W-1:0] hue_ff, hue_in;

   logic accept;
   logic [lrpe_pkg::ELAPSED_W-1:0] elapsed_inc;
   logic [lrpe_pkg::PERIOD_W-1:0] period;
   logic [lrpe_pkg::COLOR_W-1:0] level_step;
   logic [lrpe_pkg::HUE_W-1:0] hue_step;
   logic [2:0] mode_wr;

   assign req_stall = queue_full;
   assign accept = req_valid && !queue_full;
   assign csr_ready = 1'b1;
   assign mode_wr = csr_data[lrpe_pkg::MODE_W-1:0];

   // configuration writes, mode clamped to the last animation
   always_comb begin
      mode_in = mode_ff;
      slow_in = slow_ff;
      blink_per_in = blink_per_ff;
      fast_in = fast_ff;
      if (csr_valid) begin
         case (lrpe_pkg::csr_index_type'(csr_index))
            lrpe_pkg::CSR_MODE: begin
               mode_in = (mode_wr > 3'(lrpe_pkg::MODE_RAINBOW)) ? lrpe_pkg::MODE_RAINBOW
                                                                : lrpe_pkg::mode_type'(mode_wr);
            end
            lrpe_pkg::CSR_SLOW: slow_in = csr_data;
            lrpe_pkg::CSR_BLINK: blink_per_in = csr_data;
            lrpe_pkg::CSR_FAST: fast_in = csr_data;
            default: ;
         endcase
      end
   end

   // saturating time, the active period and the next breathe level and hue step
   always_comb begin
      elapsed_inc = (elapsed_ff < lrpe_pkg::ELAPSED_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
      case (mode_ff)
         lrpe_pkg::MODE_SOLID, lrpe_pkg::MODE_FOLLOWING: period = slow_ff;
         lrpe_pkg::MODE_BLINK: period = blink_per_ff;
         default: period = fast_ff;
      endcase
      if (falling_ff) begin
         level_step = (level_ff != '0) ? level_ff - 1'b1 : level_ff;
      end else begin
         level_step = (level_ff != lrpe_pkg::COLOR_MAX) ? level_ff + 1'b1 : level_ff;
      end
      hue_step = hue_ff + 1'b1;
   end

   // classify the item and advance the animation state
   always_comb begin
      elapsed_in = elapsed_ff;
      fill_in = fill_ff;
      phase_in = phase_ff;
      falling_in = falling_ff;
      level_in = level_ff;
      hue_in = hue_ff;
      push = 1'b0;
      push_cmd.kind = lrpe_pkg::CMD_FRM_OFF;
      push_cmd.mask = req_led_mask;
      push_cmd.pos = req_led_position;
      push_cmd.color = '{red: req_red_in, green: req_green_in, blue: req_blue_in};
      push_cmd.param = '0;
      if (accept) begin
         case (lrpe_pkg::action_type'(req_action))
            lrpe_pkg::ACT_PRIMARY: begin
               push = 1'b1;
               push_cmd.kind = lrpe_pkg::CMD_WR_PRIMARY;
            end
            lrpe_pkg::ACT_ALTERNATE: begin
               push = 1'b1;
               push_cmd.kind = lrpe_pkg::CMD_WR_ALTERNATE;
            end
            lrpe_pkg::ACT_TICK: begin
               elapsed_in = elapsed_inc;
               if (mode_ff == lrpe_pkg::MODE_OFF) begin
                  push = 1'b1;
                  push_cmd.kind = lrpe_pkg::CMD_FRM_OFF;
               end else if (elapsed_inc > lrpe_pkg::ELAPSED_W'(period)) begin
                  elapsed_in = '0;
                  push = 1'b1;
                  case (mode_ff)
                     lrpe_pkg::MODE_SOLID: push_cmd.kind = lrpe_pkg::CMD_FRM_PRIMARY;
                     lrpe_pkg::MODE_FOLLOWING: begin
                        push_cmd.kind = lrpe_pkg::CMD_FRM_FILL;
                        push_cmd.param = lrpe_pkg::PARAM_W'(fill_ff);
                        fill_in = (fill_ff == lrpe_pkg::FILL_W'(lrpe_pkg::LED_COUNT))
                                  ? '0 : fill_ff + 1'b1;
                     end
                     lrpe_pkg::MODE_BLINK: begin
                        push_cmd.kind = phase_ff ? lrpe_pkg::CMD_FRM_ALTERNATE
                                                 : lrpe_pkg::CMD_FRM_PRIMARY;
                        phase_in = !phase_ff;
                     end
                     lrpe_pkg::MODE_BREATHE: begin
                        push_cmd.kind = lrpe_pkg::CMD_FRM_BREATHE;
                        push_cmd.param = level_step;
                        level_in = level_step;
                        if (!falling_ff && level_step == lrpe_pkg::COLOR_MAX) begin
                           falling_in = 1'b1;
                        end else if (falling_ff && level_step == '0) begin
                           falling_in = 1'b0;
                        end
                     end
                     default: begin
                        push_cmd.kind = lrpe_pkg::CMD_FRM_RAINBOW;
                        push_cmd.param = hue_step[lrpe_pkg::PARAM_W-1:0];
                        hue_in = hue_step[lrpe_pkg::HUE_W-1] ? '0 : hue_step;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lrpe_pkg::MODE_OFF;
         slow_ff <= lrpe_pkg::SLOW_RESET;
         blink_per_ff <= lrpe_pkg::BLINK_RESET;
         fast_ff <= lrpe_pkg::FAST_RESET;
         elapsed_ff <= '0;
         fill_ff <= '0;
         phase_ff <= 1'b0;
         falling_ff <= 1'b0;
         level_ff <= '0;
         hue_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         slow_ff <= slow_in;
         blink_per_ff <= blink_per_in;
         fast_ff <= fast_in;
         elapsed_ff <= elapsed_in;
         fill_ff <= fill_in;
         phase_ff <= phase_in;
         falling_ff <= falling_in;
         level_ff <= level_in;
         hue_ff <= hue_in;
      end
   end

endmodule

// ----- design/lrpe_back.sv -----
module lrpe_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               queue_not_empty,
   input  lrpe_pkg::cmd_type                  head,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lrpe_pkg::IDX_OUT_W-1:0]     rsp_led_index,
   output logic [lrpe_pkg::COLOR_W-1:0]       rsp_red_out,
   output logic [lrpe_pkg::COLOR_W-1:0]       rsp_green_out,
   output logic [lrpe_pkg::COLOR_W-1:0]       rsp_blue_out,
   output logic                               rsp_frame_end
);

   localparam int PROD_W = 2 * lrpe_pkg::COLOR_W;
   localparam int EXT_W = 64;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } back_state_type;

   // exact floor(x / 255) for a product of two color channels
   function automatic logic [lrpe_pkg::COLOR_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] t;
      t = (PROD_W + 1)'(x) + (PROD_W + 1)'(1) + (PROD_W + 1)'(x >> lrpe_pkg::COLOR_W);
      return t[PROD_W-1:lrpe_pkg::COLOR_W];
   endfunction

   back_state_type state_ff, state_in;
   logic [lrpe_pkg::LED_W-1:0] led_ff, led_in;
   lrpe_pkg::cmd_kind_type frm_kind_ff, frm_kind_in;
   logic [lrpe_pkg::PARAM_W-1:0] frm_param_ff, frm_param_in;

   lrpe_pkg::rgb_type prim_ff [lrpe_pkg::LED_COUNT];
   lrpe_pkg::rgb_type alt_ff [lrpe_pkg::LED_COUNT];

   logic s1_valid_ff, s1_valid_in;
   logic [lrpe_pkg::LED_W-1:0] s1_index_ff;
   logic s1_last_ff;
   logic s1_scale_ff;
   logic [PROD_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [PROD_W-1:0] s1_red_in, s1_green_in, s1_blue_in;

   logic out_valid_ff, out_valid_in;

   logic advance;
   logic issue;
   logic last_led;
   logic is_write;
   logic [EXT_W-1:0] mask_ext;
   logic [lrpe_pkg::LED_W-1:0] rev;
   lrpe_pkg::rgb_type prim_sel, alt_sel, wheel_c;

   assign advance = !out_valid_ff || !rsp_stall;
   assign issue = (state_ff == ST_RUN) && advance;
   assign last_led = (led_ff == lrpe_pkg::LED_W'(lrpe_pkg::LED_COUNT - 1));
   assign pop = (state_ff == ST_IDLE) && queue_not_empty;
   assign is_write = (head.kind == lrpe_pkg::CMD_WR_PRIMARY) ||
                     (head.kind == lrpe_pkg::CMD_WR_ALTERNATE);
   assign mask_ext = EXT_W'(head.mask);

   // sequencer: one command per idle cycle, one led per cycle in a frame while the output is not stalled
   always_comb begin
      state_in = state_ff;
      led_in = led_ff;
      frm_kind_in = frm_kind_ff;
      frm_param_in = frm_param_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop && !is_write) begin
               state_in = ST_RUN;
               led_in = '0;
               frm_kind_in = head.kind;
               frm_param_in = head.param;
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (last_led) begin
                  state_in = ST_IDLE;
               end else begin
                  led_in = led_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         led_ff <= '0;
      end else begin
         state_ff <= state_in;
         led_ff <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      frm_kind_ff <= frm_kind_in;
      frm_param_ff <= frm_param_in;
   end

   // color stores, written when a write command leaves the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lrpe_pkg::LED_COUNT; i++) begin
            prim_ff[i] <= lrpe_pkg::PRIMARY_RESET;
            alt_ff[i] <= '0;
         end
      end else if (pop) begin
         for (int i = 0; i < lrpe_pkg::LED_COUNT; i++) begin
            if (head.kind == lrpe_pkg::CMD_WR_PRIMARY && i < lrpe_pkg::MASK_W &&
                mask_ext[i]) begin
               prim_ff[i] <= head.color;
            end
            if (head.kind == lrpe_pkg::CMD_WR_ALTERNATE &&
                (head.pos == '0 || 7'(head.pos) == 7'(i + 1))) begin
               alt_ff[i] <= head.color;
            end
         end
      end
   end

   // issue stage: pick the led color or start the breathe product
   always_comb begin
      prim_sel = prim_ff[led_ff];
      alt_sel = alt_ff[led_ff];
      rev = lrpe_pkg::LED_W'(lrpe_pkg::LED_COUNT - 1) - led_ff;
      wheel_c = lrpe_pkg::wheel(lrpe_pkg::HUE_BASE[rev] + frm_param_ff);
      s1_red_in = '0;
      s1_green_in = '0;
      s1_blue_in = '0;
      case (frm_kind_ff)
         lrpe_pkg::CMD_FRM_PRIMARY: begin
            s1_red_in = PROD_W'(prim_sel.red);
            s1_green_in = PROD_W'(prim_sel.green);
            s1_blue_in = PROD_W'(prim_sel.blue);
         end
         lrpe_pkg::CMD_FRM_ALTERNATE: begin
            s1_red_in = PROD_W'(alt_sel.red);
            s1_green_in = PROD_W'(alt_sel.green);
            s1_blue_in = PROD_W'(alt_sel.blue);
         end
         lrpe_pkg::CMD_FRM_FILL: begin
            if (lrpe_pkg::PARAM_W'(led_ff) < frm_param_ff) begin
               s1_red_in = PROD_W'(prim_sel.red);
               s1_green_in = PROD_W'(prim_sel.green);
               s1_blue_in = PROD_W'(prim_sel.blue);
            end
         end
         lrpe_pkg::CMD_FRM_BREATHE: begin
            s1_red_in = PROD_W'(prim_sel.red) * PROD_W'(frm_param_ff);
            s1_green_in = PROD_W'(prim_sel.green) * PROD_W'(frm_param_ff);
            s1_blue_in = PROD_W'(prim_sel.blue) * PROD_W'(frm_param_ff);
         end
         lrpe_pkg::CMD_FRM_RAINBOW: begin
            s1_red_in = PROD_W'(wheel_c.red);
            s1_green_in = PROD_W'(wheel_c.green);
            s1_blue_in = PROD_W'(wheel_c.blue);
         end
         default: ;
      endcase
   end

   // pipeline valids move together whenever the output can take data
   always_comb begin
      s1_valid_in = advance ? issue : s1_valid_ff;
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_index_ff <= led_ff;
         s1_last_ff <= last_led;
         s1_scale_ff <= (frm_kind_ff == lrpe_pkg::CMD_FRM_BREATHE);
         s1_red_ff <= s1_red_in;
         s1_green_ff <= s1_green_in;
         s1_blue_ff <= s1_blue_in;
      end
   end

   // output register: finish the brightness scaling
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_led_index <= lrpe_pkg::IDX_OUT_W'(s1_index_ff);
         rsp_frame_end <= s1_last_ff;
         rsp_red_out <= s1_scale_ff ? div255(s1_red_ff) : s1_red_ff[lrpe_pkg::COLOR_W-1:0];
         rsp_green_out <= s1_scale_ff ? div255(s1_green_ff)
                                      : s1_green_ff[lrpe_pkg::COLOR_W-1:0];
         rsp_blue_out <= s1_scale_ff ? div255(s1_blue_ff) : s1_blue_ff[lrpe_pkg::COLOR_W-1:0];
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- design/led_ring_pattern_engine_unit.sv -----
// a frame's first led is offered after its tick passes the command queue, the back end
// pop into run, the issue stage and the output register; a frame holds the back end
// for one pop, then one led a cycle for its 12 leds while not stalled, a color write
// for its pop alone; the front takes one item a cycle until the 4-entry queue fills
// reset: synchronous, restores default periods, mode off, primaries to 0,0,100 at once
module led_ring_pattern_engine_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lrpe_pkg::ACTION_W-1:0]       req_action,
   input  logic [lrpe_pkg::MASK_W-1:0]         req_led_mask,
   input  logic [lrpe_pkg::POS_W-1:0]          req_led_position,
   input  logic [lrpe_pkg::COLOR_W-1:0]        req_red_in,
   input  logic [lrpe_pkg::COLOR_W-1:0]        req_green_in,
   input  logic [lrpe_pkg::COLOR_W-1:0]        req_blue_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lrpe_pkg::IDX_OUT_W-1:0]      rsp_led_index,
   output logic [lrpe_pkg::COLOR_W-1:0]        rsp_red_out,
   output logic [lrpe_pkg::COLOR_W-1:0]        rsp_green_out,
   output logic [lrpe_pkg::COLOR_W-1:0]        rsp_blue_out,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lrpe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lrpe_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic push;
   lrpe_pkg::cmd_type push_cmd;
   logic queue_full;
   logic pop;
   logic queue_not_empty;
   lrpe_pkg::cmd_type head;

   // front: takes items, keeps the timers and animation state
   lrpe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_led_mask     (req_led_mask),
      .req_led_position (req_led_position),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .push             (push),
      .push_cmd         (push_cmd),
      .queue_full       (queue_full)
   );

   // command queue
   lrpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   // back: color stores and frame generation
   lrpe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_led_index   (rsp_led_index),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

// ----- design/lrpe_checker.sv -----
module lrpe_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [lrpe_pkg::IDX_OUT_W-1:0]      rsp_led_index,
   input logic [lrpe_pkg::COLOR_W-1:0]        rsp_red_out,
   input logic [lrpe_pkg::COLOR_W-1:0]        rsp_green_out,
   input logic [lrpe_pkg::COLOR_W-1:0]        rsp_blue_out,
   input logic                                rsp_frame_end
);

   localparam logic [lrpe_pkg::IDX_OUT_W-1:0] LAST_IDX =
      lrpe_pkg::IDX_OUT_W'(lrpe_pkg::LED_COUNT - 1);

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_led_index) &&
      $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out) &&
      $stable(rsp_frame_end))
      else $error("stalled result changed");

   // frame end marks exactly the last led
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_end == (rsp_led_index == LAST_IDX)))
      else $error("frame end flag does not match led index");

   // leds of a frame follow back to back in order
   a_next_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_frame_end |=>
      rsp_valid && (rsp_led_index == $past(rsp_led_index) + 1'b1))
      else $error("led sequence broken inside a frame");

   // a new frame starts at led zero
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_frame_end |=> !rsp_valid || rsp_led_index == '0)
      else $error("frame does not start at led zero");

   // nothing offered right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind led_ring_pattern_engine_unit lrpe_checker u_lrpe_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_led_index (rsp_led_index),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_frame_end (rsp_frame_end)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import lrpe_pkg::*;

   // action code that the block has to ignore
   localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

   localparam int IDLE_MAX = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES = 3;
   localparam int PHASE_ITEMS = 50;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] led;
      rgb_type              color;
      logic                 frame_end;
   } led_result_type;

   // predicts led frames from accepted items and checks the block's output
   class led_frame_board;
      rgb_type                primary_colors [LED_COUNT];
      rgb_type                alternate_colors [LED_COUNT];
      logic [ELAPSED_W-1:0]   elapsed_ms;
      int                     fill_count;
      bit                     show_alternate;
      bit                     breathe_falling;
      logic [COLOR_W-1:0]     breathe_level;
      logic [HUE_W-1:0]       hue_offset;
      mode_type               mode;
      logic [PERIOD_W-1:0]    slow_period;
      logic [PERIOD_W-1:0]    blink_period;
      logic [PERIOD_W-1:0]    fast_period;
      led_result_type         pending_leds [$];
      int                     errors;

      function new();
         for (int j = 0; j < LED_COUNT; j++) begin
            primary_colors[j] = PRIMARY_RESET;
            alternate_colors[j] = '0;
         end
         elapsed_ms = '0;
         fill_count = 0;
         show_alternate = 1'b0;
         breathe_falling = 1'b0;
         breathe_level = '0;
         hue_offset = '0;
         mode = MODE_OFF;
         slow_period = SLOW_RESET;
         blink_period = BLINK_RESET;
         fast_period = FAST_RESET;
         errors = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MODE: begin
               // codes above rainbow clamp to rainbow
               if (data[MODE_W-1:0] > MODE_W'(MODE_RAINBOW)) mode = MODE_RAINBOW;
               else mode = mode_type'(data[MODE_W-1:0]);
            end
            CSR_SLOW:  slow_period = data;
            CSR_BLINK: blink_period = data;
            CSR_FAST:  fast_period = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_leds.size();
      endfunction

      function void push_led(int j, rgb_type c);
         led_result_type res;
         res.led = IDX_OUT_W'(j);
         res.color = c;
         res.frame_end = (j == LED_COUNT - 1);
         pending_leds.push_back(res);
      endfunction

      // three-segment hue wheel
      function rgb_type color_wheel(logic [COLOR_W-1:0] p);
         rgb_type c;
         int q;
         q = 255 - int'(p);
         if (q < 85) begin
            c.red = 8'(255 - 3 * q);
            c.green = '0;
            c.blue = 8'(3 * q);
         end else if (q < 170) begin
            q -= 85;
            c.red = '0;
            c.green = 8'(3 * q);
            c.blue = 8'(255 - 3 * q);
         end else begin
            q -= 170;
            c.red = 8'(3 * q);
            c.green = 8'(255 - 3 * q);
            c.blue = '0;
         end
         return c;
      endfunction

      // one millisecond passes
      function void advance_one_ms();
         logic [PERIOD_W-1:0] period;
         rgb_type c;
         int k;
         if (elapsed_ms != ELAPSED_MAX) elapsed_ms++;
         // off frame on every tick, time keeps running
         if (mode == MODE_OFF) begin
            for (int j = 0; j < LED_COUNT; j++) push_led(j, '0);
            return;
         end
         case (mode)
            MODE_SOLID, MODE_FOLLOWING: period = slow_period;
            MODE_BLINK:                 period = blink_period;
            default:                    period = fast_period;
         endcase
         if (elapsed_ms <= {1'b0, period}) return;
         elapsed_ms = '0;
         case (mode)
            MODE_SOLID: begin
               for (int j = 0; j < LED_COUNT; j++) push_led(j, primary_colors[j]);
            end
            MODE_FOLLOWING: begin
               for (int j = 0; j < LED_COUNT; j++)
                  push_led(j, (j < fill_count) ? primary_colors[j] : rgb_type'('0));
               fill_count = (fill_count + 1 >= LED_COUNT + 1) ? 0 : fill_count + 1;
            end
            MODE_BLINK: begin
               for (int j = 0; j < LED_COUNT; j++)
                  push_led(j, show_alternate ? alternate_colors[j] : primary_colors[j]);
               show_alternate = !show_alternate;
            end
            MODE_BREATHE: begin
               if (!breathe_falling) begin
                  if (breathe_level != COLOR_MAX) breathe_level++;
               end else if (breathe_level != '0) begin
                  breathe_level--;
               end
               for (int j = 0; j < LED_COUNT; j++) begin
                  c.red = 8'((int'(primary_colors[j].red) * int'(breathe_level)) / 255);
                  c.green = 8'((int'(primary_colors[j].green) * int'(breathe_level)) / 255);
                  c.blue = 8'((int'(primary_colors[j].blue) * int'(breathe_level)) / 255);
                  push_led(j, c);
               end
               if (!breathe_falling && breathe_level == COLOR_MAX) breathe_falling = 1'b1;
               else if (breathe_falling && breathe_level == '0) breathe_falling = 1'b0;
            end
            default: begin
               hue_offset = hue_offset + 1'b1;
               for (int j = 0; j < LED_COUNT; j++) begin
                  k = LED_COUNT - 1 - j;
                  push_led(j, color_wheel(8'((k * 256) / LED_COUNT + int'(hue_offset))));
               end
               if (hue_offset > 9'd255) hue_offset = '0;
            end
         endcase
      endfunction

      function void note_input(logic [ACTION_W-1:0] action, logic [MASK_W-1:0] mask,
                               logic [POS_W-1:0] pos, rgb_type color);
         case (action)
            ACT_PRIMARY: begin
               for (int j = 0; j < LED_COUNT && j < MASK_W; j++)
                  if (mask[j]) primary_colors[j] = color;
            end
            ACT_ALTERNATE: begin
               // position 0 writes the whole ring, beyond the ring is dropped
               if (pos == '0) begin
                  for (int j = 0; j < LED_COUNT; j++) alternate_colors[j] = color;
               end else if (int'(pos) <= LED_COUNT) begin
                  alternate_colors[int'(pos) - 1] = color;
               end
            end
            ACT_TICK: advance_one_ms();
            default: ;
         endcase
      endfunction

      function void compare_field(string name, int exp_value, int act_value);
         if (exp_value != act_value) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_value, act_value);
            errors++;
         end
      endfunction

      function void check_result(led_result_type act);
         led_result_type exp_led;
         if (pending_leds.size() == 0) begin
            $display("%0t: unexpected led transfer, expected none, actual led %0d",
                     $time, act.led);
            errors++;
            return;
         end
         exp_led = pending_leds.pop_front();
         compare_field("led_index", exp_led.led, act.led);
         compare_field("red_out", exp_led.color.red, act.color.red);
         compare_field("green_out", exp_led.color.green, act.color.green);
         compare_field("blue_out", exp_led.color.blue, act.color.blue);
         compare_field("frame_end", exp_led.frame_end, act.frame_end);
      endfunction

      function void report_leftovers();
         if (pending_leds.size() != 0) begin
            $display("%0t: led transfers missing, expected %0d more, actual 0",
                     $time, pending_leds.size());
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ACTION_W-1:0]    req_action = ACT_TICK;
   logic [MASK_W-1:0]      req_led_mask = '0;
   logic [POS_W-1:0]       req_led_position = '0;
   logic [COLOR_W-1:0]     req_red_in = '0;
   logic [COLOR_W-1:0]     req_green_in = '0;
   logic [COLOR_W-1:0]     req_blue_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [IDX_OUT_W-1:0]   rsp_led_index;
   logic [COLOR_W-1:0]     rsp_red_out;
   logic [COLOR_W-1:0]     rsp_green_out;
   logic [COLOR_W-1:0]     rsp_blue_out;
   logic                   rsp_frame_end;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_MODE;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   led_frame_board         board;
   bit                     req_idle_en = 1'b0;
   bit                     rsp_idle_en = 1'b0;
   int                     rsp_hold_request = 0;
   int                     quiet_cycles = 0;

   led_ring_pattern_engine_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_led_mask     (req_led_mask),
      .req_led_position (req_led_position),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_led_index    (rsp_led_index),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_frame_end    (rsp_frame_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: random stall before each transfer, long hold on request
   initial begin : led_receiver
      int gap;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = rsp_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
         if (rsp_hold_request != 0) begin
            gap = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // check every led transfer
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0 && board != null)
         board.check_result('{led: rsp_led_index,
                              color: '{red: rsp_red_out, green: rsp_green_out,
                                       blue: rsp_blue_out},
                              frame_end: rsp_frame_end});
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one item transfer, valid stays up for a following item
   task automatic send_item(input logic [ACTION_W-1:0] action, input logic [MASK_W-1:0] mask,
                            input logic [POS_W-1:0] pos, input rgb_type color);
      int gap;
      gap = req_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_led_mask <= mask;
      req_led_position <= pos;
      req_red_in <= color.red;
      req_green_in <= color.green;
      req_blue_in <= color.blue;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_input(action, mask, pos, color);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(ACT_TICK, MASK_W'($urandom), POS_W'($urandom),
                               rgb_type'(24'($urandom)));
   endtask

   task automatic send_random_item(input int tick_percent);
      int pick;
      logic [ACTION_W-1:0] action;
      logic [POS_W-1:0] pos;
      pick = $urandom_range(0, 99);
      if (pick < tick_percent) action = ACT_TICK;
      else if (pick < tick_percent + (100 - tick_percent) / 2) action = ACT_PRIMARY;
      else if (pick < 96) action = ACT_ALTERNATE;
      else action = ACT_RESERVED;
      // mostly positions on the ring
      pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, LED_COUNT));
      send_item(action, MASK_W'($urandom), pos, rgb_type'(24'($urandom)));
   endtask

   // wait until the block has drained everything it accepted
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.write_register(idx, data);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] mode_data,
                             input logic [PERIOD_W-1:0] slow, input logic [PERIOD_W-1:0] blink,
                             input logic [PERIOD_W-1:0] fast);
      settle();
      write_csr(CSR_MODE, mode_data);
      write_csr(CSR_SLOW, slow);
      write_csr(CSR_BLINK, blink);
      write_csr(CSR_FAST, fast);
      csr_valid <= 1'b0;
   endtask

   // mostly short periods, sometimes the extremes
   function automatic logic [PERIOD_W-1:0] pick_period();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return PERIOD_W'($urandom_range(0, 6));
   endfunction

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] mode_data;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state: off frame, then solid at the default slow period
      send_ticks(1);
      settle();
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_SOLID));
      csr_valid <= 1'b0;
      send_ticks(101);

      // color writes, edge positions and masks, ignored action
      set_config(CSR_DATA_W'(MODE_SOLID), '0, '0, '0);
      send_item(ACT_PRIMARY, 12'hFFF, 4'd0, '{8'hFF, 8'hFF, 8'hFF});
      send_item(ACT_PRIMARY, 12'h000, 4'd3, '{8'h12, 8'h34, 8'h56});
      send_item(ACT_PRIMARY, 12'h801, 4'd0, '{8'h00, 8'hFF, 8'h00});
      send_item(ACT_PRIMARY, 12'h0F0, 4'd0, '{8'h80, 8'h40, 8'h20});
      send_item(ACT_ALTERNATE, 12'h000, 4'd0, '{8'h00, 8'h00, 8'hFF});
      send_item(ACT_ALTERNATE, 12'hFFF, 4'd1, '{8'hFF, 8'hFF, 8'hFF});
      send_item(ACT_ALTERNATE, 12'h000, 4'd12, '{8'h11, 8'h22, 8'h33});
      send_item(ACT_ALTERNATE, 12'h000, 4'd13, '{8'hAA, 8'hAA, 8'hAA});
      send_item(ACT_ALTERNATE, 12'h000, 4'd15, '{8'h55, 8'h55, 8'h55});
      send_item(ACT_RESERVED, 12'hFFF, 4'd0, '{8'hFF, 8'hFF, 8'hFF});
      send_ticks(1);

      // each animation once with zero periods
      set_config(CSR_DATA_W'(MODE_BLINK), '0, '0, '0);
      send_ticks(2);
      set_config(CSR_DATA_W'(MODE_FOLLOWING), '0, '0, '0);
      send_ticks(2);
      set_config(CSR_DATA_W'(MODE_BREATHE), '0, '0, '0);
      send_ticks(2);
      set_config(CSR_DATA_W'(MODE_RAINBOW), '0, '0, '0);
      send_ticks(1);
      // mode codes above rainbow
      set_config(CSR_DATA_W'(6), '0, '0, '0);
      send_ticks(1);
      set_config(10'h3FF, '0, '0, '0);
      send_ticks(1);
      set_config(CSR_DATA_W'(MODE_OFF), '1, '1, '1);
      send_ticks(1);

      // breathe up to full brightness and a few steps back down
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      set_config(CSR_DATA_W'(MODE_BREATHE), '0, '0, '0);
      send_ticks(258);
      // rainbow steps mixed with color writes
      set_config(CSR_DATA_W'(MODE_RAINBOW), '0, '0, 10'd0);
      repeat (40) send_random_item(95);

      // random phases
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            mode_data = CSR_DATA_W'(MODE_SOLID);
            set_config(mode_data, '0, pick_period(), pick_period());
         end else if (phase == 1) begin
            set_config(CSR_DATA_W'(MODE_FOLLOWING), '0, pick_period(), pick_period());
         end else begin
            mode_data = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom)
                                                    : CSR_DATA_W'($urandom_range(0, 5));
            set_config(mode_data, pick_period(), pick_period(), pick_period());
         end
         req_idle_en = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
         rsp_idle_en = ($urandom_range(0, 3) != 0);
         // long result hold while the sender keeps pushing
         if (phase == 0) rsp_hold_request = HOLD_CYCLES;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender pause until everything has come out
            if (phase == 0 && n == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (board.pending() != 0);
            end
            send_random_item(60);
         end
      end

      // drain and finish
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      board.report_leftovers();
      if (board.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
